// File: rtl/half_open_interval_alu_unit_assert.svh
// Assertion macros for the half-open interval ALU.
`ifndef HALF_OPEN_INTERVAL_ALU_UNIT_ASSERT_SVH
`define HALF_OPEN_INTERVAL_ALU_UNIT_ASSERT_SVH

// Consequent in the same cycle.
`define HOIA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interval alu check failed");

// Consequent in the next cycle.
`define HOIA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interval alu check failed");

`endif

// File: rtl/hoia_pkg.sv
// Shared types and constants for the half-open interval ALU.
package hoia_pkg;
  localparam int DATA_W = 32;
  localparam int LANES  = 4;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [LANES-1:0][DATA_W-1:0] quad_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DIVZERO = 2'd2
  } status_t;

  // Travels alongside the divider lanes.
  typedef struct packed {
    op_t              op;
    status_t          st;
    word_t            lo;
    word_t            hi;
    quad_t            prod;
    logic [LANES-1:0] neg;
  } side_t;
endpackage

// File: rtl/hoia_front.sv
// Input capture, operand checks, add/subtract, corner products and divider set-up.
module hoia_front import hoia_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       vld_i,
  input  logic [1:0] opcode_i,
  input  word_t      a_lower_i,
  input  word_t      a_upper_i,
  input  word_t      b_lower_i,
  input  word_t      b_upper_i,
  output logic       vld0_o,
  output logic       vld_o,
  output side_t      side_o,
  output quad_t      num_o,
  output quad_t      den_o
);
  logic  vld0_r, vld1_r;
  op_t   op_r;
  word_t al_r, au_r, bl_r, bu_r;
  side_t side_r, side_nxt;
  quad_t num_r, num_nxt, den_r, den_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
    end else if (en) begin
      vld0_r <= vld_i;
      vld1_r <= vld0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r   <= op_t'(opcode_i);
      al_r   <= a_lower_i;
      au_r   <= a_upper_i;
      bl_r   <= b_lower_i;
      bu_r   <= b_upper_i;
      side_r <= side_nxt;
      num_r  <= num_nxt;
      den_r  <= den_nxt;
    end
  end

  always_comb begin
    word_t ai, bi;
    word_t ca [LANES];
    word_t cb [LANES];
    logic  empty;
    ai    = au_r - word_t'(1);
    bi    = bu_r - word_t'(1);
    ca[0] = al_r; cb[0] = bl_r;
    ca[1] = al_r; cb[1] = bi;
    ca[2] = ai;   cb[2] = bl_r;
    ca[3] = ai;   cb[3] = bi;
    empty = !($signed(al_r) < $signed(au_r)) || !($signed(bl_r) < $signed(bu_r));
    side_nxt.op = op_r;
    side_nxt.lo = '0;
    side_nxt.hi = '0;
    priority if (empty) begin
      side_nxt.st = ST_EMPTY;
    end else if (op_r == OP_DIV && !($signed(bl_r) > 0) && !($signed(bi) < 0)) begin
      side_nxt.st = ST_DIVZERO;
    end else begin
      side_nxt.st = ST_OK;
    end
    unique case (op_r)
      OP_ADD: begin
        side_nxt.lo = al_r + bl_r;
        side_nxt.hi = au_r + bi;
      end
      OP_SUB: begin
        side_nxt.lo = al_r - bi;
        side_nxt.hi = au_r - bl_r;
      end
      default: begin
        side_nxt.lo = '0;
        side_nxt.hi = '0;
      end
    endcase
    for (int k = 0; k < LANES; k++) begin
      side_nxt.prod[k] = word_t'(ca[k] * cb[k]);
      side_nxt.neg[k]  = ca[k][DATA_W-1] ^ cb[k][DATA_W-1];
      num_nxt[k] = ca[k][DATA_W-1] ? word_t'(-ca[k]) : ca[k];
      den_nxt[k] = cb[k][DATA_W-1] ? word_t'(-cb[k]) : cb[k];
    end
  end

  assign vld0_o = vld0_r;
  assign vld_o  = vld1_r;
  assign side_o = side_r;
  assign num_o  = num_r;
  assign den_o  = den_r;
endmodule

// File: rtl/hoia_div_pipe.sv
// Four-lane unsigned restoring divider, one quotient bit per stage.
module hoia_div_pipe import hoia_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vld_i,
  input  side_t side_i,
  input  quad_t num_i,
  input  quad_t den_i,
  output logic  vld_o,
  output side_t side_o,
  output quad_t quo_o
);
  logic  vld_r  [DATA_W];
  side_t side_r [DATA_W];
  quad_t rem_r  [DATA_W];
  quad_t nq_r   [DATA_W];
  quad_t den_r  [DATA_W];

  for (genvar s = 0; s < DATA_W; s++) begin : g_stage
    logic  vld_c;
    side_t side_c;
    quad_t rem_c, nq_c, den_c, rem_nxt, nq_nxt;

    if (s == 0) begin : g_first
      assign vld_c  = vld_i;
      assign side_c = side_i;
      assign rem_c  = '0;
      assign nq_c   = num_i;
      assign den_c  = den_i;
    end else begin : g_next
      assign vld_c  = vld_r[s-1];
      assign side_c = side_r[s-1];
      assign rem_c  = rem_r[s-1];
      assign nq_c   = nq_r[s-1];
      assign den_c  = den_r[s-1];
    end

    always_comb begin
      logic [DATA_W:0] shifted, diff;
      shifted = '0;
      diff    = '0;
      for (int l = 0; l < LANES; l++) begin
        shifted = {rem_c[l], nq_c[l][DATA_W-1]};
        diff    = shifted - {1'b0, den_c[l]};
        if (!diff[DATA_W]) begin
          rem_nxt[l] = diff[DATA_W-1:0];
          nq_nxt[l]  = {nq_c[l][DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt[l] = shifted[DATA_W-1:0];
          nq_nxt[l]  = {nq_c[l][DATA_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= side_c;
        rem_r[s]  <= rem_nxt;
        nq_r[s]   <= nq_nxt;
        den_r[s]  <= den_c;
      end
    end
  end

  assign vld_o  = vld_r[DATA_W-1];
  assign side_o = side_r[DATA_W-1];
  assign quo_o  = nq_r[DATA_W-1];
endmodule

// File: rtl/hoia_back.sv
// Corner selection, min/max tree and result register.
module hoia_back import hoia_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    vld_i,
  input  side_t   side_i,
  input  quad_t   quo_i,
  output logic    vld_o,
  output word_t   lo_o,
  output word_t   hi_o,
  output status_t st_o
);
  logic    va_r, vb_r, vc_r;
  op_t     op_a_r, op_b_r;
  status_t st_a_r, st_b_r, st_c_r;
  word_t   lo_a_r, hi_a_r, lo_b_r, hi_b_r, lo_c_r, hi_c_r;
  quad_t   c_r, c_nxt;
  word_t   mn01_r, mn23_r, mx01_r, mx23_r;
  word_t   lo_nxt, hi_nxt;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (side_i.op == OP_DIV) begin
        c_nxt[k] = side_i.neg[k] ? word_t'(-quo_i[k]) : quo_i[k];
      end else begin
        c_nxt[k] = side_i.prod[k];
      end
    end
  end

  always_comb begin
    word_t mn, mx;
    mn = ($signed(mn23_r) < $signed(mn01_r)) ? mn23_r : mn01_r;
    mx = ($signed(mx01_r) < $signed(mx23_r)) ? mx23_r : mx01_r;
    if (st_b_r != ST_OK) begin
      lo_nxt = '0;
      hi_nxt = '0;
    end else if (op_b_r == OP_ADD || op_b_r == OP_SUB) begin
      lo_nxt = lo_b_r;
      hi_nxt = hi_b_r;
    end else begin
      lo_nxt = mn;
      hi_nxt = mx + word_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= vld_i;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_a_r <= side_i.op;
      st_a_r <= side_i.st;
      lo_a_r <= side_i.lo;
      hi_a_r <= side_i.hi;
      c_r    <= c_nxt;
      op_b_r <= op_a_r;
      st_b_r <= st_a_r;
      lo_b_r <= lo_a_r;
      hi_b_r <= hi_a_r;
      mn01_r <= ($signed(c_r[1]) < $signed(c_r[0])) ? c_r[1] : c_r[0];
      mn23_r <= ($signed(c_r[3]) < $signed(c_r[2])) ? c_r[3] : c_r[2];
      mx01_r <= ($signed(c_r[0]) < $signed(c_r[1])) ? c_r[1] : c_r[0];
      mx23_r <= ($signed(c_r[2]) < $signed(c_r[3])) ? c_r[3] : c_r[2];
      st_c_r <= st_b_r;
      lo_c_r <= lo_nxt;
      hi_c_r <= hi_nxt;
    end
  end

  assign vld_o = vc_r;
  assign lo_o  = lo_c_r;
  assign hi_o  = hi_c_r;
  assign st_o  = st_c_r;
endmodule

// File: rtl/half_open_interval_alu_unit.sv
// Half-open interval ALU top level: add, subtract, multiply, divide on [lower, upper).
// One beat is taken every cycle while the result register is free or being drained;
// each beat goes through the front, divider and back stages, the depth being set by
// the divider, which resolves one quotient bit per stage in four parallel lanes. A
// stall on the result side freezes the whole pipeline, so nothing is dropped or doubled.
module half_open_interval_alu_unit import hoia_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic signed [DATA_W-1:0] in_a_lower,
  input  logic signed [DATA_W-1:0] in_a_upper,
  input  logic signed [DATA_W-1:0] in_b_lower,
  input  logic signed [DATA_W-1:0] in_b_upper,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [DATA_W-1:0] out_res_lower,
  output logic signed [DATA_W-1:0] out_res_upper,
  output logic [1:0]  out_status
);
  logic    en, vld0, f_vld, d_vld, b_vld;
  side_t   f_side, d_side;
  quad_t   f_num, f_den, d_quo;
  word_t   lo, hi;
  status_t st;

  assign en       = !b_vld || out_ready;
  assign in_ready = en;

  hoia_front u_front (
    .clk, .rst_n, .en,
    .vld_i     (in_valid && in_ready),
    .opcode_i  (in_opcode),
    .a_lower_i (in_a_lower),
    .a_upper_i (in_a_upper),
    .b_lower_i (in_b_lower),
    .b_upper_i (in_b_upper),
    .vld0_o    (vld0),
    .vld_o     (f_vld),
    .side_o    (f_side),
    .num_o     (f_num),
    .den_o     (f_den)
  );

  hoia_div_pipe u_div (
    .clk, .rst_n, .en,
    .vld_i  (f_vld),
    .side_i (f_side),
    .num_i  (f_num),
    .den_i  (f_den),
    .vld_o  (d_vld),
    .side_o (d_side),
    .quo_o  (d_quo)
  );

  hoia_back u_back (
    .clk, .rst_n, .en,
    .vld_i  (d_vld),
    .side_i (d_side),
    .quo_i  (d_quo),
    .vld_o  (b_vld),
    .lo_o   (lo),
    .hi_o   (hi),
    .st_o   (st)
  );

  assign out_valid     = b_vld;
  assign out_res_lower = lo;
  assign out_res_upper = hi;
  assign out_status    = st;

`include "half_open_interval_alu_unit_assert.svh"

  `HOIA_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld0)
  `HOIA_ASSERT_NOW(a_status_code, out_valid, out_status != 2'd3)
  `HOIA_ASSERT_NOW(a_fault_zero, out_valid && out_status != ST_OK, out_res_lower == 0 && out_res_upper == 0)
  `HOIA_ASSERT_NEXT(a_stall_freeze, !in_ready, $stable(f_vld) && $stable(d_vld))
endmodule
